[hw/rtl/deque_with_reverse_top_macros.svh]
// assertion macros shared by the deque modules
`ifndef DEQUE_WITH_REVERSE_TOP_MACROS_SVH
`define DEQUE_WITH_REVERSE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define DWR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DWR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dwr_pkg.sv]
// shared types and constants of the deque with reverse
`default_nettype none

package dwr_pkg;

    // ring geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int WORD_W = 32;

    // request codes
    typedef enum logic [2:0] {
        REQ_POP_BACK   = 3'd0,
        REQ_POP_FRONT  = 3'd1,
        REQ_REVERSE    = 3'd2,
        REQ_PUSH_BACK  = 3'd3,
        REQ_PUSH_FRONT = 3'd4
    } req_code_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_POPPED = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2
    } status_code_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic in_exec;
        logic do_op;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_pop;
        logic is_push;
        logic is_rev;
        logic empty;
        logic full;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/dwr_ram.sv]
// generic single-port ram with registered read
`default_nettype none

module dwr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dwr_ctrl.sv]
// request sequencer of the deque
`default_nettype none
`include "deque_with_reverse_top_macros.svh"

module dwr_ctrl import dwr_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.in_exec = 1'b1;
                priority if (stat.is_pop && !stat.empty) begin
                    cmd.do_op  = 1'b1;
                    state_next = S_RDWAIT;
                end else if (stat.is_pop || (stat.is_push && stat.full)) begin
                    state_next = S_EMIT;
                end else begin
                    cmd.do_op  = stat.is_push || stat.is_rev;
                    state_next = S_IDLE;
                end
            end
            S_RDWAIT: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencing checks
    `DWR_ASSERT_NXT(a_accept_exec, s_valid && s_ready, state_reg == S_EXEC, "accept must execute")
    `DWR_ASSERT_NXT(a_read_emit, state_reg == S_RDWAIT, state_reg == S_EMIT, "read must emit")
    `DWR_ASSERT_IMP(a_emit_load, cmd.load_out, state_reg == S_EMIT && stat.out_free,
                    "result loaded outside emit")

endmodule

`default_nettype wire

[hw/rtl/dwr_dp.sv]
// ring pointers, entry ram and result register of the deque
`default_nettype none
`include "deque_with_reverse_top_macros.svh"

module dwr_dp import dwr_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [2:0]               s_req_type,
    input  wire logic signed [WORD_W-1:0] s_push_value,
    input  wire dp_cmd_t                  cmd,
    output dp_stat_t                      stat,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [1:0]                    m_status,
    output logic signed [WORD_W-1:0]      m_pop_value
);

    logic [2:0]        req_reg;
    logic [WORD_W-1:0] word_reg;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rev_reg, rev_next;
    logic              err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [WORD_W-1:0] out_value_reg, out_value_next;

    logic [SUM_W-1:0]  tail_sum, high_sum;
    logic [ADDR_W-1:0] tail_addr, high_addr, head_inc, head_dec, ram_addr;
    logic [WORD_W-1:0] ram_rdata;
    logic              low_side, ram_we, ram_re;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg  <= s_req_type;
            word_reg <= s_push_value;
        end
    end

    // request decode
    always_comb begin
        stat.is_pop   = (req_reg == REQ_POP_BACK) || (req_reg == REQ_POP_FRONT);
        stat.is_push  = (req_reg == REQ_PUSH_BACK) || (req_reg == REQ_PUSH_FRONT);
        stat.is_rev   = (req_reg == REQ_REVERSE);
        stat.empty    = (count_reg == '0);
        stat.full     = (count_reg == CNT_W'(DEPTH));
        stat.out_free = !out_valid_reg || m_ready;
        low_side      = ((req_reg == REQ_POP_FRONT) || (req_reg == REQ_PUSH_FRONT)) ^ rev_reg;
    end

    // ring address arithmetic
    always_comb begin
        tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
        high_sum  = tail_sum - SUM_W'(1);
        tail_addr = (tail_sum >= SUM_W'(DEPTH)) ? ADDR_W'(tail_sum - SUM_W'(DEPTH))
                                                : ADDR_W'(tail_sum);
        high_addr = (high_sum >= SUM_W'(DEPTH)) ? ADDR_W'(high_sum - SUM_W'(DEPTH))
                                                : ADDR_W'(high_sum);
        head_inc  = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);
        head_dec  = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);
    end

    // pointer update and ram access
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = low_side ? head_reg : high_addr;
        if (cmd.do_op) begin
            priority if (stat.is_rev) begin
                rev_next = !rev_reg;
            end else if (stat.is_pop) begin
                ram_re     = 1'b1;
                count_next = count_reg - CNT_W'(1);
                if (low_side) begin
                    head_next = head_inc;
                end
            end else if (stat.is_push) begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
                if (low_side) begin
                    head_next = head_dec;
                    ram_addr  = head_dec;
                end else begin
                    ram_addr  = tail_addr;
                end
            end
        end
    end

    // error note and result register
    always_comb begin
        err_next        = cmd.in_exec ? (stat.is_pop ? stat.empty : stat.full) : err_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
            priority if (!err_reg) begin
                out_status_next = ST_POPPED;
                out_value_next  = ram_rdata;
            end else if (stat.is_pop) begin
                out_status_next = ST_EMPTY;
                out_value_next  = '0;
            end else begin
                out_status_next = ST_FULL;
                out_value_next  = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        err_reg        <= err_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    dwr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (word_reg),
        .rdata (ram_rdata)
    );

    assign m_valid     = out_valid_reg;
    assign m_status    = out_status_reg;
    assign m_pop_value = out_value_reg;

    // pointer checks
    `DWR_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(DEPTH), "count beyond depth")
    `DWR_ASSERT_IMP(a_head_range, 1'b1, head_reg <= ADDR_W'(DEPTH - 1), "head beyond ring")
    `DWR_ASSERT_NXT(a_push_count, cmd.do_op && stat.is_push,
                    count_reg == $past(count_reg) + CNT_W'(1), "push must grow count")

endmodule

`default_nettype wire

[hw/rtl/deque_with_reverse_top.sv]
// Bounded double-ended queue of 1024 signed 32-bit words with a constant-time
// reverse, kept in a ring buffer with a head pointer, a count and a reversed
// flag. One request is worked at a time: a push into a deque that is not full,
// a reverse or an unused code goes from execute straight back to idle, where
// the next request can be accepted. A pop loads the result register after
// execute, the registered read of the single-port entry ram, then the load,
// and an error result after execute and the load; the next request can be
// accepted in the cycle after that load. A result waiting in the output
// register does not block acceptance of the next request; only a further
// result waits for it, held in the emit state for as long as the register
// stays full. Entries read back only after being written, so the ram needs no
// clearing after reset.
`default_nettype none

module deque_with_reverse_top import dwr_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [2:0]               s_req_type,
    input  wire logic signed [WORD_W-1:0] s_push_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [1:0]                    m_status,
    output logic signed [WORD_W-1:0]      m_pop_value
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // request sequencer
    dwr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // ring datapath
    dwr_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_req_type   (s_req_type),
        .s_push_value (s_push_value),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_pop_value  (m_pop_value)
    );

endmodule

`default_nettype wire
